@@ src/depth_of_field_scatter_macros.svh @@
// Assertion macros for the depth of field scatter RTL.
`ifndef DEPTH_OF_FIELD_SCATTER_MACROS_SVH
`define DEPTH_OF_FIELD_SCATTER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DOF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define DOF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/dof_pkg.sv @@
// Shared types, constants and tables of the depth of field scatter block.
`default_nettype none
package dof_pkg;
    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 256;
    localparam int ADDR_W  = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
    localparam int COORD_W = 14;
    localparam int CNT_W   = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_SCATTER = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] CFG_FOCUS = 3'd0;
    localparam logic [2:0] CFG_LENS  = 3'd1;
    localparam logic [2:0] CFG_GAIN  = 3'd2;
    localparam logic [2:0] CFG_MAXR  = 3'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [4:0]  radius;
    } t_cmd;

    typedef logic [CNT_W-1:0] t_cnt_tab [32];

    function automatic t_cnt_tab disc_counts();
        t_cnt_tab tab;
        int n;
        for (int r = 0; r < 32; r++) begin
            n = 0;
            for (int dy = -r; dy <= r; dy++) begin
                for (int dx = -r; dx <= r; dx++) begin
                    if (dx * dx + dy * dy < r * r) begin
                        n++;
                    end
                end
            end
            if (r == 0) begin
                n = 1;
            end
            tab[r] = CNT_W'(n);
        end
        return tab;
    endfunction

    localparam t_cnt_tab DISC_COUNT = disc_counts();
endpackage
`default_nettype wire

@@ src/depth_of_field_scatter.sv @@
// Top level of the depth of field scatter accumulator.
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     opcode, position, colour, depth
//  result    out        o_out_valid / i_out_stall   sum_red, sum_green, sum_blue
//  config    in         i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
// The front end handles one word at a time and stalls its input until it is done; a scatter
// word passes multiply, divide, clamp and colour-divide steps (no divide with zero focus),
// a word whose disc adds nothing is dropped, and a push waits on a full queue. The back end
// sweeps each offset, adds each in-frame disc pixel and holds a read while the output stalls.
// After reset a clearing pass zeroes the store with the input stalled.
// A stalled result holds while a four-word queue lets the front end keep working.
`default_nettype none
module depth_of_field_scatter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_x_position,
    input  wire logic [7:0]  i_y_position,
    input  wire logic [15:0] i_red,
    input  wire logic [15:0] i_green,
    input  wire logic [15:0] i_blue,
    input  wire logic [15:0] i_depth,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [23:0]      o_sum_red,
    output logic [23:0]      o_sum_green,
    output logic [23:0]      o_sum_blue,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import dof_pkg::*;

    logic clearing, q_full, q_empty, push, pop;
    t_cmd push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    dof_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_x_position(i_x_position), .i_y_position(i_y_position),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue), .i_depth(i_depth),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_clearing(clearing), .i_q_full(q_full), .o_push(push), .o_cmd(push_cmd)
    );

    dof_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(push_cmd), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_cmd(head_cmd)
    );

    dof_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .i_cmd(head_cmd), .o_pop(pop), .o_clearing(clearing),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_sum_red(o_sum_red), .o_sum_green(o_sum_green), .o_sum_blue(o_sum_blue)
    );
endmodule
`default_nettype wire

@@ src/dof_front.sv @@
// Front end: accepts words, computes the blur radius and the per-pixel colour share.
`default_nettype none
module dof_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_opcode,
    input  wire logic [7:0]   i_x_position,
    input  wire logic [7:0]   i_y_position,
    input  wire logic [15:0]  i_red,
    input  wire logic [15:0]  i_green,
    input  wire logic [15:0]  i_blue,
    input  wire logic [15:0]  i_depth,
    input  wire logic         i_cfg_valid,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         i_clearing,
    input  wire logic         i_q_full,
    output logic              o_push,
    output dof_pkg::t_cmd     o_cmd
);
    import dof_pkg::*;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL1  = 3'd1;
    localparam logic [2:0] F_MUL2  = 3'd2;
    localparam logic [2:0] F_DIV   = 3'd3;
    localparam logic [2:0] F_CLAMP = 3'd4;
    localparam logic [2:0] F_CDIV  = 3'd5;
    localparam logic [2:0] F_PUSH  = 3'd6;

    logic [2:0]  r_state;
    logic [15:0] r_focus, r_lens;
    logic [7:0]  r_gain;
    logic [4:0]  r_maxr;
    logic [1:0]  r_op;
    logic [7:0]  r_x, r_y;
    logic [15:0] r_col [3];
    logic [15:0] r_depth;
    logic [32:0] r_near;
    logic [31:0] r_fd;
    logic [23:0] r_gdr;
    logic [15:0] r_diff;
    logic [32:0] r_den;
    logic [39:0] r_rem;
    logic [5:0]  r_quo;
    logic        r_ovf;
    logic [2:0]  r_k;
    logic [4:0]  r_rad;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_qr [3];
    logic [CNT_W:0] r_rm [3];
    logic [3:0]  r_step;

    logic [39:0] den_sh;
    logic [4:0]  n_rad;
    logic [CNT_W:0] part [3];

    assign den_sh = {7'b0, r_den} << r_k;
    assign n_rad = (r_ovf || (r_quo > {1'b0, r_maxr})) ? r_maxr : r_quo[4:0];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            part[c] = {r_rm[c][CNT_W-1:0], r_qr[c][15]};
        end
    end

    assign o_in_stall = (r_state != F_IDLE) || i_clearing;
    assign o_push = (r_state == F_PUSH) && !i_q_full;
    assign o_cmd = '{op: r_op, x: r_x, y: r_y, red: r_qr[0], green: r_qr[1],
                     blue: r_qr[2], radius: r_rad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_focus <= 16'd1280;
            r_lens  <= 16'd256;
            r_gain  <= 8'd40;
            r_maxr  <= 5'd16;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FOCUS: r_focus <= i_cfg_data;
                    CFG_LENS:  r_lens  <= i_cfg_data;
                    CFG_GAIN:  r_gain  <= i_cfg_data[7:0];
                    CFG_MAXR:  r_maxr  <= i_cfg_data[4:0];
                    default:   ;
                endcase
            end
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid && !i_clearing) begin
                        r_op <= i_opcode;
                        r_x <= i_x_position;
                        r_y <= i_y_position;
                        r_col[0] <= i_red;
                        r_col[1] <= i_green;
                        r_col[2] <= i_blue;
                        r_qr[0] <= i_red;
                        r_qr[1] <= i_green;
                        r_qr[2] <= i_blue;
                        r_rad <= 5'd0;
                        r_depth <= i_depth;
                        if (i_opcode == OP_SCATTER) begin
                            r_state <= F_MUL1;
                        end else if (i_opcode != OP_NONE) begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_MUL1: begin
                    r_near <= 33'(r_depth) * 33'({1'b0, r_focus} + {1'b0, r_lens});
                    r_fd   <= 32'(r_focus) * 32'(r_lens);
                    r_gdr  <= 24'(r_gain) * 24'(r_lens);
                    r_diff <= (r_depth > r_focus) ? r_depth - r_focus : r_focus - r_depth;
                    r_den  <= {r_depth, 1'b0} * 33'(r_focus);
                    r_state <= F_MUL2;
                end
                F_MUL2: begin
                    r_quo <= 6'd0;
                    r_k <= 3'd6;
                    r_ovf <= 1'b0;
                    r_rem <= 40'(r_gdr) * 40'(r_diff);
                    if (r_near <= 33'(r_fd)) begin
                        r_state <= F_IDLE;
                    end else if (r_focus == 16'd0) begin
                        r_ovf <= 1'b1;
                        r_state <= F_CLAMP;
                    end else begin
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (r_rem >= den_sh) begin
                        r_rem <= r_rem - den_sh;
                        if (r_k == 3'd6) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_quo <= r_quo | (6'd1 << r_k);
                        end
                    end
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        r_state <= F_CLAMP;
                    end
                end
                F_CLAMP: begin
                    r_rad <= n_rad;
                    r_cnt <= DISC_COUNT[n_rad];
                    for (int c = 0; c < 3; c++) begin
                        r_qr[c] <= r_col[c];
                        r_rm[c] <= '0;
                    end
                    r_step <= 4'd15;
                    r_state <= F_CDIV;
                end
                F_CDIV: begin
                    for (int c = 0; c < 3; c++) begin
                        if (part[c] >= {1'b0, r_cnt}) begin
                            r_rm[c] <= part[c] - {1'b0, r_cnt};
                            r_qr[c] <= {r_qr[c][14:0], 1'b1};
                        end else begin
                            r_rm[c] <= part[c];
                            r_qr[c] <= {r_qr[c][14:0], 1'b0};
                        end
                    end
                    r_step <= r_step - 4'd1;
                    if (r_step == 4'd0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/dof_queue.sv @@
// Short command queue between the front end and the accumulation engine.
`default_nettype none
module dof_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dof_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output dof_pkg::t_cmd      o_cmd
);
    import dof_pkg::*;

    t_cmd r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wr] <= i_cmd;
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ src/dof_back.sv @@
// Accumulation engine: clears the store after reset, sweeps blur discs over it and serves pixel reads.
`default_nettype none
`include "depth_of_field_scatter_macros.svh"
module dof_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire dof_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [23:0]        o_sum_red,
    output logic [23:0]        o_sum_green,
    output logic [23:0]        o_sum_blue
);
    import dof_pkg::*;

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_SCAN  = 3'd2;
    localparam logic [2:0] B_ACC   = 3'd3;
    localparam logic [2:0] B_RDQ   = 3'd4;
    localparam logic [2:0] B_RDD   = 3'd5;

    logic [23:0] mem_r [FRAME_WIDTH * FRAME_HEIGHT];
    logic [23:0] mem_g [FRAME_WIDTH * FRAME_HEIGHT];
    logic [23:0] mem_b [FRAME_WIDTH * FRAME_HEIGHT];

    logic [2:0]  r_state;
    t_cmd        r_cmd;
    logic signed [5:0] r_dx, r_dy;
    logic [ADDR_W-1:0] r_addr, r_clr;
    logic        r_hit;
    logic [23:0] r_rd [3];
    logic        r_out_valid;
    logic [23:0] r_out [3];

    logic signed [11:0] dxe, dye, dist_sq;
    logic [11:0] lim;
    logic signed [5:0] rad_s;
    logic signed [COORD_W-1:0] px, py, cx, cy;
    logic in_disc, in_fr, center_in, last, out_free;
    logic [ADDR_W-1:0] scan_addr, center_addr;
    logic mem_re, mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [23:0] wdat [3];
    logic [15:0] share [3];
    logic [24:0] sum [3];

    assign rad_s = $signed({1'b0, r_cmd.radius});
    assign dxe = 12'(r_dx);
    assign dye = 12'(r_dy);
    assign dist_sq = dxe * dxe + dye * dye;
    assign lim = 12'(r_cmd.radius) * 12'(r_cmd.radius);
    assign in_disc = ($unsigned(dist_sq) < lim) || (r_cmd.radius == 5'd0);
    assign px = $signed(COORD_W'(r_cmd.x)) + COORD_W'(r_dx);
    assign py = $signed(COORD_W'(r_cmd.y)) + COORD_W'(r_dy);
    assign in_fr = (px >= 0) && (px < $signed(COORD_W'(FRAME_WIDTH)))
                && (py >= 0) && (py < $signed(COORD_W'(FRAME_HEIGHT)));
    assign scan_addr = ADDR_W'(int'(py) * FRAME_WIDTH + int'(px));
    assign cx = $signed(COORD_W'(i_cmd.x));
    assign cy = $signed(COORD_W'(i_cmd.y));
    assign center_in = (cx < $signed(COORD_W'(FRAME_WIDTH)))
                    && (cy < $signed(COORD_W'(FRAME_HEIGHT)));
    assign center_addr = ADDR_W'(int'(cy) * FRAME_WIDTH + int'(cx));
    assign last = (r_dx == rad_s) && (r_dy == rad_s);
    assign out_free = !r_out_valid || !i_out_stall;

    assign share[0] = r_cmd.red;
    assign share[1] = r_cmd.green;
    assign share[2] = r_cmd.blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = {1'b0, r_rd[c]} + 25'(share[c]);
        end
        mem_re = 1'b0;
        mem_we = 1'b0;
        rd_addr = scan_addr;
        for (int c = 0; c < 3; c++) begin
            wdat[c] = '0;
        end
        case (r_state)
            B_CLEAR: mem_we = 1'b1;
            B_SCAN:  mem_re = in_disc && in_fr;
            B_ACC: begin
                mem_we = 1'b1;
                for (int c = 0; c < 3; c++) begin
                    wdat[c] = sum[c][24] ? 24'hFFFFFF : sum[c][23:0];
                end
            end
            B_RDQ: begin
                mem_re = 1'b1;
                rd_addr = r_addr;
            end
            B_RDD:   mem_we = out_free && r_hit && (r_cmd.op == OP_CLEAR);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_r[(r_state == B_CLEAR) ? r_clr : r_addr] <= wdat[0];
            mem_g[(r_state == B_CLEAR) ? r_clr : r_addr] <= wdat[1];
            mem_b[(r_state == B_CLEAR) ? r_clr : r_addr] <= wdat[2];
        end
        if (mem_re) begin
            r_rd[0] <= mem_r[rd_addr];
            r_rd[1] <= mem_g[rd_addr];
            r_rd[2] <= mem_b[rd_addr];
        end
    end

    assign o_pop = (r_state == B_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == B_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_sum_red = r_out[0];
    assign o_sum_green = r_out[1];
    assign o_sum_blue = r_out[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == B_RDD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_cmd;
                        r_dx <= -$signed({1'b0, i_cmd.radius});
                        r_dy <= -$signed({1'b0, i_cmd.radius});
                        r_addr <= center_addr;
                        r_hit <= center_in;
                        if (i_cmd.op == OP_SCATTER) begin
                            r_state <= B_SCAN;
                        end else if (center_in) begin
                            r_state <= B_RDQ;
                        end else begin
                            r_state <= B_RDD;
                        end
                    end
                end
                B_SCAN, B_ACC: begin
                    if ((r_state == B_SCAN) && in_disc && in_fr) begin
                        r_addr <= scan_addr;
                        r_state <= B_ACC;
                    end else begin
                        if (r_dx == rad_s) begin
                            r_dx <= -rad_s;
                            r_dy <= r_dy + 6'sd1;
                        end else begin
                            r_dx <= r_dx + 6'sd1;
                        end
                        r_state <= last ? B_IDLE : B_SCAN;
                    end
                end
                B_RDQ: r_state <= B_RDD;
                B_RDD: begin
                    if (out_free) begin
                        for (int c = 0; c < 3; c++) begin
                            r_out[c] <= r_hit ? r_rd[c] : 24'd0;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `DOF_ASSERT_SAME(a_no_pop_clear, r_state == B_CLEAR, !o_pop)
    `DOF_ASSERT_SAME(a_acc_after_scan, r_state == B_ACC, $past(r_state) == B_SCAN)
    `DOF_ASSERT_NEXT(a_result_loaded, (r_state == B_RDD) && out_free, r_out_valid)
endmodule
`default_nettype wire
